FILE: hw/rtl/sopci_pkg.sv
// ============================================================================
// sopci_pkg - shared types and constants
// Field widths, character codes and divider handshake structs for the
// sum-of-pairs column identity block.
// ============================================================================
`default_nettype none

package sopci_pkg;

    localparam int RES_W       = 8;    // residue character
    localparam int CNT_W       = 11;   // per-letter, item and gap counters
    localparam int COL_ID_W    = 20;   // identical pairs within one column
    localparam int ALL_PAIRS_W = 21;   // C(N,2) for an 11-bit N
    localparam int TOT_W       = 40;   // alignment totals
    localparam int MCOL_W      = 17;   // match column count
    localparam int Q_W         = 16;   // Q0.16 fractions
    localparam int DEN_G_W     = MCOL_W + ALL_PAIRS_W;

    localparam int ALPHABET_SIZE = 26;
    localparam int LETTER_AW     = $clog2(ALPHABET_SIZE);
    localparam int MAX_COLUMNS   = 65536;

    localparam logic [MCOL_W-1:0] MATCH_COL_MAX = MCOL_W'(MAX_COLUMNS);
    localparam logic [CNT_W-1:0]  NUM_SEQ_RESET = CNT_W'(2);

    localparam logic [RES_W-1:0] CHAR_A   = 8'h41;
    localparam logic [RES_W-1:0] CHAR_Z   = 8'h5A;
    localparam logic [RES_W-1:0] CHAR_GAP = 8'h2D;

    localparam int DIV_STEPS = Q_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // Output word layout
    localparam int M_DATA_BITS = 2 * TOT_W + MCOL_W + 2 * Q_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_USER_W    = 2;

    typedef struct packed {
        logic             start;
        logic [TOT_W-1:0] num;
        logic [TOT_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sum_of_pairs_column_identity_top.sv
// ============================================================================
// sum_of_pairs_column_identity_top - sum-of-pairs identity over an alignment
// Counts identical and aligned residue pairs column by column and reports
// totals and Q0.16 identity fractions at the end of each alignment.
// ============================================================================
// Usage:
//   Input words carry one residue each (s_tdata), column by column; s_tuser
//   marks the last residue of a column and s_tlast the last residue of the
//   alignment. cfg_we/cfg_wdata set the sequence count N; the user must do so
//   only while idle; the block does not enforce it. Residues are taken one per
//   cycle while s_tready is high. Per-letter counts live in a 26-entry memory
//   read the cycle a word is taken and written back the next, with forwarding
//   for repeated letters; per-column valid bits clear it at once. A closed
//   column passes three more stages (gap pairs multiply, pair subtract, total
//   update) before it reaches the totals. After the alignment-end word, s_tready
//   drops for pipeline drain, the denominator multiply and two 16-step fraction
//   divisions on one shared divider. The result then moves into the output
//   register and input resumes even if m_tready is low; a second result waits
//   for that register. Reset clears all counts and totals and sets N to 2.
// ============================================================================
`default_nettype none

module sum_of_pairs_column_identity_top (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_we,
    input  wire [sopci_pkg::CNT_W-1:0]        cfg_wdata,    // num_sequences
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [sopci_pkg::RES_W-1:0]        s_tdata,      // [7:0] residue
    input  wire [0:0]                         s_tuser,      // [0] column_end
    input  wire                               s_tlast,      // alignment_end
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [39:0] identical_pairs, [79:40] aligned_pairs, [96:80] match_columns,
    // [112:97] global_identity, [128:113] approx_identity, rest zero
    output logic [sopci_pkg::M_DATA_W-1:0]    m_tdata,
    output logic [sopci_pkg::M_USER_W-1:0]    m_tuser       // [0] length_error,
                                                            // [1] empty_alignment
);
    import sopci_pkg::*;

    typedef enum logic [7:0] {
        ST_RUN     = 8'b0000_0001,
        ST_DRAIN   = 8'b0000_0010,
        ST_DEN     = 8'b0000_0100,
        ST_START_G = 8'b0000_1000,
        ST_WAIT_G  = 8'b0001_0000,
        ST_START_A = 8'b0010_0000,
        ST_WAIT_A  = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // ---------------- configuration ----------------
    logic [CNT_W-1:0]       num_seq_reg;
    logic [ALL_PAIRS_W-1:0] all_pairs_reg;
    logic [2*CNT_W-1:0]     all_prod;

    assign all_prod = num_seq_reg * (num_seq_reg - CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_seq_reg <= NUM_SEQ_RESET;
        end else if (cfg_we) begin
            num_seq_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        all_pairs_reg <= all_prod[2*CNT_W-1:1];
    end

    // ---------------- stage 1: accept, issue memory read ----------------
    logic                 s_accept;
    logic                 s_upper;
    logic                 s_gap;
    logic [RES_W-1:0]     s_ofs;
    logic [LETTER_AW-1:0] rd_addr;

    assign s_tready = (state_reg == ST_RUN);
    assign s_accept = s_tvalid && s_tready;
    assign s_upper  = (s_tdata >= CHAR_A) && (s_tdata <= CHAR_Z);
    assign s_gap    = (s_tdata == CHAR_GAP);
    assign s_ofs    = s_tdata - CHAR_A;
    assign rd_addr  = s_upper ? s_ofs[LETTER_AW-1:0] : '0;

    logic                 s2_valid_reg;
    logic                 s2_upper_reg;
    logic                 s2_gap_reg;
    logic                 s2_ce_reg;
    logic                 s2_ae_reg;
    logic [LETTER_AW-1:0] s2_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s2_upper_reg <= s_upper;
            s2_gap_reg   <= s_gap;
            s2_ce_reg    <= s_tuser[0];
            s2_ae_reg    <= s_tlast;
            s2_addr_reg  <= rd_addr;
        end
    end

    // ---------------- letter count memory ----------------
    logic [CNT_W-1:0] cnt_mem [ALPHABET_SIZE];
    logic [CNT_W-1:0] mem_rdata_reg;
    logic             mem_we;
    logic [CNT_W-1:0] cnt_upd;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mem_rdata_reg <= cnt_mem[rd_addr];
        end
        if (mem_we) begin
            cnt_mem[s2_addr_reg] <= cnt_upd;
        end
    end

    // ---------------- stage 2: column read-modify-write ----------------
    logic [ALPHABET_SIZE-1:0] col_valid_reg;
    logic [CNT_W-1:0]         col_cnt_reg;
    logic [CNT_W-1:0]         col_gaps_reg;
    logic                     col_match_reg;
    logic [COL_ID_W-1:0]      col_ident_reg;

    logic                 fwd_valid_reg;
    logic [LETTER_AW-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]     fwd_data_reg;

    logic                match2;
    logic                fwd_hit;
    logic [CNT_W-1:0]    cnt_old;
    logic [COL_ID_W:0]   id_sum;
    logic [COL_ID_W-1:0] ident_next;
    logic [CNT_W-1:0]    item_next;
    logic [CNT_W-1:0]    gaps_next;
    logic                col_close;

    assign match2  = (col_cnt_reg == '0) ? (s2_upper_reg || s2_gap_reg) : col_match_reg;
    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == s2_addr_reg);
    assign cnt_old = !col_valid_reg[s2_addr_reg] ? '0
                   : (fwd_hit ? fwd_data_reg : mem_rdata_reg);
    assign cnt_upd = (cnt_old == '1) ? cnt_old : cnt_old + CNT_W'(1);
    assign id_sum  = {1'b0, col_ident_reg} + (COL_ID_W + 1)'(cnt_old);
    assign mem_we  = s2_valid_reg && match2 && s2_upper_reg;

    assign ident_next = !mem_we ? col_ident_reg
                      : (id_sum[COL_ID_W] ? '1 : id_sum[COL_ID_W-1:0]);
    assign item_next  = (col_cnt_reg == '1) ? col_cnt_reg : col_cnt_reg + CNT_W'(1);
    assign gaps_next  = (match2 && s2_gap_reg && (col_gaps_reg != '1))
                      ? col_gaps_reg + CNT_W'(1) : col_gaps_reg;
    assign col_close  = s2_valid_reg && (s2_ce_reg || s2_ae_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_valid_reg <= '0;
            col_cnt_reg   <= '0;
            col_gaps_reg  <= '0;
            col_match_reg <= 1'b0;
            col_ident_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= mem_we;
            if (s2_valid_reg) begin
                if (col_close) begin
                    col_valid_reg <= '0;
                    col_cnt_reg   <= '0;
                    col_gaps_reg  <= '0;
                    col_match_reg <= 1'b0;
                    col_ident_reg <= '0;
                end else begin
                    col_cnt_reg   <= item_next;
                    col_gaps_reg  <= gaps_next;
                    col_match_reg <= match2;
                    col_ident_reg <= ident_next;
                    if (mem_we) begin
                        col_valid_reg[s2_addr_reg] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= s2_addr_reg;
        fwd_data_reg <= cnt_upd;
    end

    // ---------------- stage 3: gap pairs ----------------
    logic                s3_valid_reg;
    logic                s3_ae_reg;
    logic                s3_match_reg;
    logic [CNT_W-1:0]    s3_cnt_reg;
    logic [CNT_W-1:0]    s3_gaps_reg;
    logic [COL_ID_W-1:0] s3_ident_reg;
    logic [2*CNT_W-1:0]  gap_prod;

    assign gap_prod = s3_gaps_reg * (s3_gaps_reg - CNT_W'(1));

    logic                   s4_valid_reg;
    logic                   s4_ae_reg;
    logic                   s4_match_reg;
    logic                   s4_err_reg;
    logic [ALL_PAIRS_W-1:0] s4_gp_reg;
    logic [COL_ID_W-1:0]    s4_ident_reg;

    // ---------------- stage 4: column pairs ----------------
    logic [ALL_PAIRS_W-1:0] pairs_diff;
    logic [COL_ID_W-1:0]    pairs_sat;

    assign pairs_diff = (all_pairs_reg > s4_gp_reg) ? all_pairs_reg - s4_gp_reg : '0;
    assign pairs_sat  = pairs_diff[ALL_PAIRS_W-1] ? '1 : pairs_diff[COL_ID_W-1:0];

    logic                s5_valid_reg;
    logic                s5_ae_reg;
    logic                s5_match_reg;
    logic                s5_err_reg;
    logic [COL_ID_W-1:0] s5_pairs_reg;
    logic [COL_ID_W-1:0] s5_ident_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= col_close;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s3_ae_reg    <= s2_ae_reg;
        s3_match_reg <= match2;
        s3_cnt_reg   <= item_next;
        s3_gaps_reg  <= gaps_next;
        s3_ident_reg <= ident_next;

        s4_ae_reg    <= s3_ae_reg;
        s4_match_reg <= s3_match_reg;
        s4_err_reg   <= (s3_cnt_reg != num_seq_reg);
        s4_gp_reg    <= gap_prod[2*CNT_W-1:1];
        s4_ident_reg <= s3_ident_reg;

        s5_ae_reg    <= s4_ae_reg;
        s5_match_reg <= s4_match_reg;
        s5_err_reg   <= s4_err_reg;
        s5_pairs_reg <= pairs_sat;
        s5_ident_reg <= s4_ident_reg;
    end

    // ---------------- stage 5: alignment totals ----------------
    logic [TOT_W-1:0]  id_tot_reg;
    logic [TOT_W-1:0]  al_tot_reg;
    logic [MCOL_W-1:0] mcol_reg;
    logic              err_reg;

    logic [TOT_W:0]    id_tot_sum;
    logic [TOT_W:0]    al_tot_sum;
    logic [TOT_W-1:0]  id_tot_next;
    logic [TOT_W-1:0]  al_tot_next;
    logic [MCOL_W-1:0] mcol_next;
    logic              err_next;
    logic              align_done;

    assign id_tot_sum  = {1'b0, id_tot_reg} + (TOT_W + 1)'(s5_ident_reg);
    assign al_tot_sum  = {1'b0, al_tot_reg} + (TOT_W + 1)'(s5_pairs_reg);
    assign id_tot_next = !s5_match_reg ? id_tot_reg
                       : (id_tot_sum[TOT_W] ? '1 : id_tot_sum[TOT_W-1:0]);
    assign al_tot_next = !s5_match_reg ? al_tot_reg
                       : (al_tot_sum[TOT_W] ? '1 : al_tot_sum[TOT_W-1:0]);
    assign mcol_next   = (!s5_match_reg || (mcol_reg >= MATCH_COL_MAX))
                       ? mcol_reg : mcol_reg + MCOL_W'(1);
    assign err_next    = err_reg || s5_err_reg;
    assign align_done  = s5_valid_reg && s5_ae_reg;

    logic [TOT_W-1:0]  res_ident_reg;
    logic [TOT_W-1:0]  res_aligned_reg;
    logic [MCOL_W-1:0] res_mcol_reg;
    logic              res_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_tot_reg <= '0;
            al_tot_reg <= '0;
            mcol_reg   <= '0;
            err_reg    <= 1'b0;
        end else if (s5_valid_reg) begin
            if (s5_ae_reg) begin
                id_tot_reg <= '0;
                al_tot_reg <= '0;
                mcol_reg   <= '0;
                err_reg    <= 1'b0;
            end else begin
                id_tot_reg <= id_tot_next;
                al_tot_reg <= al_tot_next;
                mcol_reg   <= mcol_next;
                err_reg    <= err_next;
            end
        end
    end

    // snapshot the finished alignment for the fraction math
    always_ff @(posedge aclk) begin
        if (align_done) begin
            res_ident_reg   <= id_tot_next;
            res_aligned_reg <= al_tot_next;
            res_mcol_reg    <= mcol_next;
            res_err_reg     <= err_next;
        end
    end

    // ---------------- fractions ----------------
    logic [DEN_G_W-1:0] den_g_reg;
    logic [Q_W-1:0]     q_g_reg;
    logic [Q_W-1:0]     q_a_reg;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DEN) begin
            den_g_reg <= res_mcol_reg * all_pairs_reg;
        end
        if (state_reg == ST_WAIT_G && div_rsp.done) begin
            q_g_reg <= div_rsp.quo;
        end
        if (state_reg == ST_WAIT_A && div_rsp.done) begin
            q_a_reg <= div_rsp.quo;
        end
    end

    assign div_req.start = (state_reg == ST_START_G) || (state_reg == ST_START_A);
    assign div_req.num   = res_ident_reg;
    assign div_req.den   = (state_reg == ST_START_G) ? TOT_W'(den_g_reg) : res_aligned_reg;

    sopci_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- control ----------------
    logic out_free;

    assign out_free = !m_tvalid || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:     if (s_accept && s_tlast) state_next = ST_DRAIN;
            ST_DRAIN:   if (align_done)          state_next = ST_DEN;
            ST_DEN:                              state_next = ST_START_G;
            ST_START_G:                          state_next = ST_WAIT_G;
            ST_WAIT_G:  if (div_rsp.done)        state_next = ST_START_A;
            ST_START_A:                          state_next = ST_WAIT_A;
            ST_WAIT_A:  if (div_rsp.done)        state_next = ST_OUT;
            ST_OUT:     if (out_free)            state_next = ST_RUN;
            default:                             state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- output register ----------------
    logic                load_out;
    logic                empty;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    assign load_out = (state_reg == ST_OUT) && out_free;
    assign empty    = (res_mcol_reg == '0) || (res_aligned_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= M_DATA_W'({empty ? '0 : q_a_reg,
                                      empty ? '0 : q_g_reg,
                                      res_mcol_reg,
                                      res_aligned_reg,
                                      res_ident_reg});
            m_tuser_reg <= {empty, res_err_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_stop_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken right after alignment end");

    a_out_from_fsm: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside output state");

    a_end_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        align_done |-> (state_reg == ST_DRAIN))
        else $error("alignment end reached totals outside drain");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_WAIT_G || state_reg == ST_WAIT_A))
        else $error("divider finished while not awaited");

    a_col_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        col_close |=> (col_valid_reg == '0 && col_cnt_reg == '0))
        else $error("column state not cleared after close");

endmodule

`default_nettype wire

FILE: hw/rtl/sopci_div.sv
// ============================================================================
// sopci_div - Q0.16 fraction divider
// Restoring divider, one quotient bit per cycle. Returns (num << 16) / den
// truncated and saturated to 16 bits; a zero denominator gives zero.
// ============================================================================
`default_nettype none

module sopci_div (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  sopci_pkg::div_req_t  req,
    output sopci_pkg::div_rsp_t  rsp
);
    import sopci_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [TOT_W-1:0]  rem_reg;
    logic [TOT_W-1:0]  den_reg;
    logic [Q_W-1:0]    quo_reg;

    logic [TOT_W:0] shifted;
    logic [TOT_W:0] diff;
    logic           fits;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                den_reg <= req.den;
                rem_reg <= req.num;
                if (req.den == '0) begin
                    quo_reg  <= '0;
                    done_reg <= 1'b1;
                end else if (req.num >= req.den) begin
                    // quotient would reach one or more: clamp
                    quo_reg  <= '1;
                    done_reg <= 1'b1;
                end else begin
                    quo_reg  <= '0;
                    busy_reg <= 1'b1;
                    step_reg <= STEP_W'(DIV_STEPS);
                end
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[TOT_W-1:0] : shifted[TOT_W-1:0];
                quo_reg  <= {quo_reg[Q_W-2:0], fits};
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire
